### design/i2c_master_byte_engine_unit_assert.svh
// Assertion macros for the I2C master byte engine.
// Included by the top level; compiles to nothing when SYNTHESIS is defined.
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define I2CM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`define I2CM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define I2CM_ASSERT_NOW(label, clk, rstn, ante, cons, msg)

`define I2CM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

### design/i2cm_pkg.sv
// Shared types and constants of the I2C master byte engine.
// Used by i2cm_step and i2c_master_byte_engine_unit; no dependencies.
package i2cm_pkg;

    localparam int DELAY_WIDTH     = 16;
    localparam int TIMEOUT_WIDTH   = 24;
    localparam int CFG_DATA_WIDTH  = 24;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int S_TDATA_WIDTH   = 16;
    localparam int S_TUSER_WIDTH   = 3;
    localparam int M_TDATA_WIDTH   = 16;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BIT_DELAY       = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STRETCH_TIMEOUT = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STRETCH_CHECK   = 2'd2;

    localparam logic [DELAY_WIDTH-1:0]   BIT_DELAY_RESET       = 16'd5;
    localparam logic [TIMEOUT_WIDTH-1:0] STRETCH_TIMEOUT_RESET = 24'd1000;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [2:0] BIT_MSB       = 3'd7;

    // phase codes: one per wait point of each command
    localparam logic [4:0] PH_START_REL    = 5'd0;
    localparam logic [4:0] PH_START_DLY_A  = 5'd1;
    localparam logic [4:0] PH_START_DLY_B  = 5'd2;
    localparam logic [4:0] PH_START_DLY_C  = 5'd3;
    localparam logic [4:0] PH_STOP_DLY_A   = 5'd4;
    localparam logic [4:0] PH_STOP_REL     = 5'd5;
    localparam logic [4:0] PH_STOP_DLY_B   = 5'd6;
    localparam logic [4:0] PH_STOP_DLY_C   = 5'd7;
    localparam logic [4:0] PH_STOP_DLY_D   = 5'd8;
    localparam logic [4:0] PH_WR_BIT_DLY   = 5'd9;
    localparam logic [4:0] PH_WR_REL       = 5'd10;
    localparam logic [4:0] PH_WR_HIGH_DLY  = 5'd11;
    localparam logic [4:0] PH_WR_LOW_DLY   = 5'd12;
    localparam logic [4:0] PH_WR_ACK_DLY   = 5'd13;
    localparam logic [4:0] PH_WR_ACK_REL   = 5'd14;
    localparam logic [4:0] PH_WR_ACK_HIGH  = 5'd15;
    localparam logic [4:0] PH_RD_DLY       = 5'd16;
    localparam logic [4:0] PH_RD_REL       = 5'd17;
    localparam logic [4:0] PH_RD_HIGH_DLY  = 5'd18;
    localparam logic [4:0] PH_RD_LOW_DLY   = 5'd19;
    localparam logic [4:0] PH_RD_ACK_DLY   = 5'd20;
    localparam logic [4:0] PH_RD_ACK_REL   = 5'd21;
    localparam logic [4:0] PH_RD_ACK_HIGH  = 5'd22;
    localparam logic [4:0] PH_IDLE         = 5'd31;

    typedef struct packed {
        logic [4:0]               phase;
        logic [1:0]               cmd;
        logic [3:0]               bit_count;
        logic [DELAY_WIDTH-1:0]   delay_count;
        logic [TIMEOUT_WIDTH-1:0] stretch_count;
        logic [7:0]               shift_byte;
        logic                     ack_choice;
        logic                     scl_drive;
        logic                     sda_drive;
        logic                     ack_flag;
        logic                     error_flag;
        logic [7:0]               read_hold;
    } i2cm_state_t;

    typedef struct packed {
        logic [DELAY_WIDTH-1:0]   bit_delay;
        logic [TIMEOUT_WIDTH-1:0] stretch_timeout;
        logic                     check_en;
    } i2cm_cfg_t;

    typedef struct packed {
        logic       cmd_valid;
        logic [1:0] opcode;
        logic [7:0] write_byte;
        logic       send_ack;
        logic       scl_in;
        logic       sda_in;
    } i2cm_item_t;

endpackage

### design/i2cm_step.sv
// Next-state logic of the I2C master byte engine for one sampled tick.
// Depends on i2cm_pkg.
module i2cm_step (
    input  i2cm_pkg::i2cm_state_t st_i,
    input  i2cm_pkg::i2cm_cfg_t   cfg_i,
    input  i2cm_pkg::i2cm_item_t  item_i,
    output i2cm_pkg::i2cm_state_t st_o,
    output logic                  done_o
);

    logic                             resume;
    logic                             is_rel;
    logic [3:0]                       bc_inc;
    logic [i2cm_pkg::DELAY_WIDTH:0]   half_sum;
    logic [i2cm_pkg::DELAY_WIDTH-1:0] half_delay;
    i2cm_pkg::i2cm_state_t            n;

    function automatic i2cm_pkg::i2cm_state_t do_delay(
        input i2cm_pkg::i2cm_state_t            s,
        input logic [4:0]                       ph,
        input logic [i2cm_pkg::DELAY_WIDTH-1:0] cnt
    );
        i2cm_pkg::i2cm_state_t r;
        r             = s;
        r.delay_count = cnt;
        r.phase       = ph;
        return r;
    endfunction

    // release SCL, then wait for it or go straight into the high delay
    function automatic i2cm_pkg::i2cm_state_t do_release(
        input i2cm_pkg::i2cm_state_t            s,
        input logic [4:0]                       ph_rel,
        input logic [4:0]                       ph_dly,
        input logic                             check,
        input logic [i2cm_pkg::DELAY_WIDTH-1:0] cnt
    );
        i2cm_pkg::i2cm_state_t r;
        r           = s;
        r.scl_drive = 1'b1;
        if (check) begin
            r.stretch_count = '0;
            r.phase         = ph_rel;
        end else begin
            r.delay_count = cnt;
            r.phase       = ph_dly;
        end
        return r;
    endfunction

    function automatic i2cm_pkg::i2cm_state_t do_finish(input i2cm_pkg::i2cm_state_t s);
        i2cm_pkg::i2cm_state_t r;
        r = s;
        if (s.cmd == i2cm_pkg::OP_READ) begin
            r.read_hold = s.shift_byte;
        end
        r.phase = i2cm_pkg::PH_IDLE;
        return r;
    endfunction

    assign half_sum   = {1'b0, cfg_i.bit_delay} + {{i2cm_pkg::DELAY_WIDTH{1'b0}}, 1'b1};
    assign half_delay = half_sum[i2cm_pkg::DELAY_WIDTH:1];

    assign is_rel = (st_i.phase == i2cm_pkg::PH_START_REL)  ||
                    (st_i.phase == i2cm_pkg::PH_STOP_REL)   ||
                    (st_i.phase == i2cm_pkg::PH_WR_REL)     ||
                    (st_i.phase == i2cm_pkg::PH_WR_ACK_REL) ||
                    (st_i.phase == i2cm_pkg::PH_RD_REL)     ||
                    (st_i.phase == i2cm_pkg::PH_RD_ACK_REL);

    always_comb begin
        n      = st_i;
        done_o = 1'b0;
        resume = 1'b0;
        bc_inc = st_i.bit_count + 4'd1;

        if (st_i.phase == i2cm_pkg::PH_IDLE) begin
            if (item_i.cmd_valid) begin
                n.cmd        = item_i.opcode;
                n.bit_count  = '0;
                n.error_flag = 1'b0;
                if (item_i.opcode == i2cm_pkg::OP_WRITE) begin
                    n.shift_byte = item_i.write_byte;
                    n.ack_flag   = 1'b0;
                end
                if (item_i.opcode == i2cm_pkg::OP_READ) begin
                    n.shift_byte = '0;
                    n.ack_choice = item_i.send_ack;
                end
                resume = 1'b1;
            end
        end else if (is_rel) begin
            if (item_i.scl_in) begin
                resume = 1'b1;
            end else if (st_i.stretch_count >= cfg_i.stretch_timeout) begin
                // drop a timeout on the read acknowledge bit
                n.error_flag = (st_i.phase != i2cm_pkg::PH_RD_ACK_REL);
                n            = do_finish(n);
                done_o       = 1'b1;
            end else begin
                n.stretch_count = st_i.stretch_count + 1'b1;
            end
        end else begin
            if (st_i.delay_count > 1) begin
                n.delay_count = st_i.delay_count - 1'b1;
            end else begin
                resume = 1'b1;
            end
        end

        if (resume) begin
            unique case (st_i.phase)
                i2cm_pkg::PH_IDLE: begin
                    unique case (n.cmd)
                        i2cm_pkg::OP_START: begin
                            n.sda_drive = 1'b1;
                            n = do_release(n, i2cm_pkg::PH_START_REL, i2cm_pkg::PH_START_DLY_A,
                                           cfg_i.check_en, cfg_i.bit_delay);
                        end
                        i2cm_pkg::OP_STOP: begin
                            n.sda_drive = 1'b0;
                            n = do_delay(n, i2cm_pkg::PH_STOP_DLY_A, cfg_i.bit_delay);
                        end
                        i2cm_pkg::OP_WRITE: begin
                            n.scl_drive = 1'b0;
                            n.sda_drive = n.shift_byte[i2cm_pkg::BIT_MSB];
                            n = do_delay(n, i2cm_pkg::PH_WR_BIT_DLY, cfg_i.bit_delay);
                        end
                        default: begin
                            n.sda_drive = 1'b1;
                            n = do_delay(n, i2cm_pkg::PH_RD_DLY, cfg_i.bit_delay);
                        end
                    endcase
                end
                i2cm_pkg::PH_START_REL:
                    n = do_delay(n, i2cm_pkg::PH_START_DLY_A, cfg_i.bit_delay);
                i2cm_pkg::PH_START_DLY_A:
                    n = do_delay(n, i2cm_pkg::PH_START_DLY_B, cfg_i.bit_delay);
                i2cm_pkg::PH_START_DLY_B: begin
                    n.sda_drive = 1'b0;
                    n = do_delay(n, i2cm_pkg::PH_START_DLY_C, cfg_i.bit_delay);
                end
                i2cm_pkg::PH_START_DLY_C: begin
                    n.scl_drive = 1'b0;
                    n      = do_finish(n);
                    done_o = 1'b1;
                end
                i2cm_pkg::PH_STOP_DLY_A:
                    n = do_release(n, i2cm_pkg::PH_STOP_REL, i2cm_pkg::PH_STOP_DLY_B,
                                   cfg_i.check_en, cfg_i.bit_delay);
                i2cm_pkg::PH_STOP_REL:
                    n = do_delay(n, i2cm_pkg::PH_STOP_DLY_B, cfg_i.bit_delay);
                i2cm_pkg::PH_STOP_DLY_B:
                    n = do_delay(n, i2cm_pkg::PH_STOP_DLY_C, cfg_i.bit_delay);
                i2cm_pkg::PH_STOP_DLY_C: begin
                    n.sda_drive = 1'b1;
                    n = do_delay(n, i2cm_pkg::PH_STOP_DLY_D, half_delay);
                end
                i2cm_pkg::PH_WR_BIT_DLY:
                    n = do_release(n, i2cm_pkg::PH_WR_REL, i2cm_pkg::PH_WR_HIGH_DLY,
                                   cfg_i.check_en, cfg_i.bit_delay);
                i2cm_pkg::PH_WR_REL:
                    n = do_delay(n, i2cm_pkg::PH_WR_HIGH_DLY, cfg_i.bit_delay);
                i2cm_pkg::PH_WR_HIGH_DLY: begin
                    n.bit_count = bc_inc;
                    n.scl_drive = 1'b0;
                    if (bc_inc < i2cm_pkg::BITS_PER_BYTE) begin
                        n.sda_drive = n.shift_byte[i2cm_pkg::BIT_MSB - bc_inc[2:0]];
                        n = do_delay(n, i2cm_pkg::PH_WR_BIT_DLY, cfg_i.bit_delay);
                    end else begin
                        n = do_delay(n, i2cm_pkg::PH_WR_LOW_DLY, cfg_i.bit_delay);
                    end
                end
                i2cm_pkg::PH_WR_LOW_DLY: begin
                    n.sda_drive = 1'b1;
                    n = do_delay(n, i2cm_pkg::PH_WR_ACK_DLY, cfg_i.bit_delay);
                end
                i2cm_pkg::PH_WR_ACK_DLY:
                    n = do_release(n, i2cm_pkg::PH_WR_ACK_REL, i2cm_pkg::PH_WR_ACK_HIGH,
                                   cfg_i.check_en, cfg_i.bit_delay);
                i2cm_pkg::PH_WR_ACK_REL:
                    n = do_delay(n, i2cm_pkg::PH_WR_ACK_HIGH, cfg_i.bit_delay);
                i2cm_pkg::PH_WR_ACK_HIGH: begin
                    n.ack_flag  = ~item_i.sda_in;
                    n.scl_drive = 1'b0;
                    n      = do_finish(n);
                    done_o = 1'b1;
                end
                i2cm_pkg::PH_RD_DLY:
                    n = do_release(n, i2cm_pkg::PH_RD_REL, i2cm_pkg::PH_RD_HIGH_DLY,
                                   cfg_i.check_en, cfg_i.bit_delay);
                i2cm_pkg::PH_RD_REL:
                    n = do_delay(n, i2cm_pkg::PH_RD_HIGH_DLY, cfg_i.bit_delay);
                i2cm_pkg::PH_RD_HIGH_DLY: begin
                    n.shift_byte = {n.shift_byte[6:0], item_i.sda_in};
                    n.scl_drive  = 1'b0;
                    n = do_delay(n, i2cm_pkg::PH_RD_LOW_DLY, half_delay);
                end
                i2cm_pkg::PH_RD_LOW_DLY: begin
                    n.bit_count = bc_inc;
                    if (bc_inc < i2cm_pkg::BITS_PER_BYTE) begin
                        n = do_release(n, i2cm_pkg::PH_RD_REL, i2cm_pkg::PH_RD_HIGH_DLY,
                                       cfg_i.check_en, cfg_i.bit_delay);
                    end else begin
                        if (n.ack_choice) begin
                            n.sda_drive = 1'b0;
                        end
                        n = do_delay(n, i2cm_pkg::PH_RD_ACK_DLY, cfg_i.bit_delay);
                    end
                end
                i2cm_pkg::PH_RD_ACK_DLY:
                    n = do_release(n, i2cm_pkg::PH_RD_ACK_REL, i2cm_pkg::PH_RD_ACK_HIGH,
                                   cfg_i.check_en, cfg_i.bit_delay);
                i2cm_pkg::PH_RD_ACK_REL:
                    n = do_delay(n, i2cm_pkg::PH_RD_ACK_HIGH, cfg_i.bit_delay);
                i2cm_pkg::PH_RD_ACK_HIGH: begin
                    n.scl_drive = 1'b0;
                    n      = do_finish(n);
                    done_o = 1'b1;
                end
                default: begin
                    n      = do_finish(n);
                    done_o = 1'b1;
                end
            endcase
        end

        st_o = n;
    end

endmodule

### design/i2c_master_byte_engine_unit.sv
// Top level of the I2C master byte engine: handshake, configuration and state registers.
// Depends on i2cm_pkg, i2cm_step and i2c_master_byte_engine_unit_assert.svh.
//
//   channel | ports            | moves
//   --------+------------------+------------------------------------------------
//   input   | s_t*             | one sampled tick: command, byte, ack choice, pins
//   result  | m_t*             | pin drives and status after that tick
//   config  | cfg_*            | register writes, no read-back
//
// One transaction per cycle unless m_ stalls; m_tdata is registered on acceptance.
// The state update is a single pass through i2cm_step between state and result registers.
// s_tready is low only while an untaken result is held and m_tready is low.
// aresetn is synchronous: idle, both lines released, state and config registers at their defaults.
`include "i2c_master_byte_engine_unit_assert.svh"

module i2c_master_byte_engine_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // write_byte[7:0], send_ack[8], scl_in[9], sda_in[10], zero fill
    input  logic [i2cm_pkg::S_TDATA_WIDTH-1:0]   s_tdata,
    // cmd_valid[0], opcode[2:1]
    input  logic [i2cm_pkg::S_TUSER_WIDTH-1:0]   s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // scl_out[0], sda_out[1], busy_res[2], done_res[3], read_byte[11:4],
    // ack_seen[12], timeout_error[13], zero fill
    output logic [i2cm_pkg::M_TDATA_WIDTH-1:0]   m_tdata,
    input  logic                                 cfg_wr_en,
    input  logic [i2cm_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_WIDTH-1:0]  cfg_wr_data
);

    i2cm_pkg::i2cm_state_t            state_reg;
    i2cm_pkg::i2cm_state_t            state_next;
    i2cm_pkg::i2cm_cfg_t              cfg_reg;
    i2cm_pkg::i2cm_item_t             item;
    logic                             done_next;
    logic                             accept;
    logic                             m_tvalid_reg;
    logic [i2cm_pkg::M_TDATA_WIDTH-1:0] m_tdata_reg;
    logic [i2cm_pkg::M_TDATA_WIDTH-1:0] m_tdata_next;

    assign item.cmd_valid  = s_tuser[0];
    assign item.opcode     = s_tuser[2:1];
    assign item.write_byte = s_tdata[7:0];
    assign item.send_ack   = s_tdata[8];
    assign item.scl_in     = s_tdata[9];
    assign item.sda_in     = s_tdata[10];

    assign s_tready = ~m_tvalid_reg | m_tready;
    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    i2cm_step u_step (
        .st_i   (state_reg),
        .cfg_i  (cfg_reg),
        .item_i (item),
        .st_o   (state_next),
        .done_o (done_next)
    );

    assign m_tdata_next = {2'b00,
                           state_next.error_flag,
                           state_next.ack_flag,
                           state_next.read_hold,
                           done_next,
                           (state_next.phase != i2cm_pkg::PH_IDLE),
                           state_next.sda_drive,
                           state_next.scl_drive};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bit_delay       <= i2cm_pkg::BIT_DELAY_RESET;
            cfg_reg.stretch_timeout <= i2cm_pkg::STRETCH_TIMEOUT_RESET;
            cfg_reg.check_en        <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                i2cm_pkg::CFG_BIT_DELAY:
                    cfg_reg.bit_delay <= cfg_wr_data[i2cm_pkg::DELAY_WIDTH-1:0];
                i2cm_pkg::CFG_STRETCH_TIMEOUT:
                    cfg_reg.stretch_timeout <= cfg_wr_data[i2cm_pkg::TIMEOUT_WIDTH-1:0];
                i2cm_pkg::CFG_STRETCH_CHECK:
                    cfg_reg.check_en <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase         <= i2cm_pkg::PH_IDLE;
            state_reg.cmd           <= i2cm_pkg::OP_START;
            state_reg.bit_count     <= '0;
            state_reg.delay_count   <= '0;
            state_reg.stretch_count <= '0;
            state_reg.shift_byte    <= '0;
            state_reg.ack_choice    <= 1'b0;
            state_reg.scl_drive     <= 1'b1;
            state_reg.sda_drive     <= 1'b1;
            state_reg.ack_flag      <= 1'b0;
            state_reg.error_flag    <= 1'b0;
            state_reg.read_hold     <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    `I2CM_ASSERT_NOW(a_done_not_busy, aclk, aresetn, m_tvalid_reg && m_tdata_reg[3], !m_tdata_reg[2], "done reported while still busy")
    `I2CM_ASSERT_NOW(a_error_scl_released, aclk, aresetn, state_reg.error_flag, state_reg.scl_drive, "timeout with SCL pulled low")
    `I2CM_ASSERT_NOW(a_bit_count_range, aclk, aresetn, 1'b1, state_reg.bit_count <= i2cm_pkg::BITS_PER_BYTE, "bit counter past one byte")
    `I2CM_ASSERT_NEXT(a_command_starts_busy, aclk, aresetn, accept && item.cmd_valid && state_reg.phase == i2cm_pkg::PH_IDLE, state_reg.phase != i2cm_pkg::PH_IDLE, "command did not enter a bus phase")

endmodule
